### sv/icc_pkg.sv
// shared types and constants of the interrupt claim/complete controller
`default_nettype none

package icc_pkg;

	localparam int SrcW    = 5;
	localparam int Leaves  = 32;
	localparam int PrioW   = 3;
	localparam int OffW    = 22;
	localparam int DataW   = 32;
	localparam int SizeW   = 4;

	localparam logic [SizeW-1:0] WordSize = 4'd4;

	localparam logic [OffW-1:0] OffPending = 22'h001000;
	localparam logic [OffW-1:0] OffMEnable = 22'h002000;
	localparam logic [OffW-1:0] OffSEnable = 22'h002080;
	localparam logic [OffW-1:0] OffMThresh = 22'h200000;
	localparam logic [OffW-1:0] OffMClaim  = 22'h200004;
	localparam logic [OffW-1:0] OffSThresh = 22'h201000;
	localparam logic [OffW-1:0] OffSClaim  = 22'h201004;

	typedef enum logic [1:0] {
		ActRead  = 2'd0,
		ActWrite = 2'd1,
		ActLine  = 2'd2,
		ActTick  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OwnerNone    = 2'd0,
		OwnerMachine = 2'd1,
		OwnerSuper   = 2'd2
	} owner_t;

	typedef logic [Leaves-1:0][PrioW-1:0] prio_vec_t;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;    // capture the input word
		logic exec;    // apply the action to the source state
		logic finish;  // move the result into the output register
	} cmd_t;

	// priority tournament over 32 leaves; a leaf of priority zero is not a candidate,
	// ties go to the lower id
	function automatic logic [SrcW-1:0] pick_best(input prio_vec_t prio);
		logic [PrioW-1:0] p [Leaves];
		logic [SrcW-1:0]  id [Leaves];
		for (int i = 0; i < Leaves; i++) begin
			p[i]  = prio[i];
			id[i] = (prio[i] != '0) ? SrcW'(i) : '0;
		end
		for (int lvl = 0; lvl < SrcW; lvl++) begin
			for (int i = 0; i < (Leaves / 2 >> lvl); i++) begin
				if (p[2*i+1] > p[2*i]) begin
					p[i]  = p[2*i+1];
					id[i] = id[2*i+1];
				end else begin
					p[i]  = p[2*i];
					id[i] = id[2*i];
				end
			end
		end
		return id[0];
	endfunction

endpackage

`default_nettype wire

### sv/icc_ctrl.sv
// sequencer of the interrupt controller: accept, execute, deliver
`default_nettype none

module icc_ctrl
	import icc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  wire logic out_stall,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		StIdle,
		StExec,
		StFinish
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (in_valid)
						state_q <= StExec;
				end
				StExec: begin
					state_q <= StFinish;
				end
				StFinish: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= StIdle;
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != StIdle);
	assign out_valid  = out_valid_q;
	assign cmd.load   = (state_q == StIdle) && in_valid;
	assign cmd.exec   = (state_q == StExec);
	assign cmd.finish = (state_q == StFinish) && slot_free;

endmodule

`default_nettype wire

### sv/icc_dp.sv
// datapath: source state, register decode, claim arbitration, result registers
`default_nettype none

module icc_dp
	import icc_pkg::*;
#(
	parameter int NUM_SOURCES = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire logic [1:0]       action,
	input  wire logic [OffW-1:0]  reg_offset,
	input  wire logic [SizeW-1:0] access_size,
	input  wire logic [DataW-1:0] write_data,
	input  wire logic [SrcW-1:0]  line_source,
	input  wire logic             line_level,
	output logic [DataW-1:0]      read_data,
	output logic                  access_error,
	output logic                  machine_irq,
	output logic                  supervisor_irq
);

	// latched input word
	action_t          action_q;
	logic [OffW-1:0]  off_q;
	logic [SizeW-1:0] size_q;
	logic [DataW-1:0] wdata_q;
	logic [SrcW-1:0]  src_q;
	logic             lvl_q;

	// per-source and per-context state
	logic [PrioW-1:0] prio_q  [1:NUM_SOURCES];
	logic             level_q [1:NUM_SOURCES];
	logic             pend_q  [1:NUM_SOURCES];
	owner_t           owner_q [1:NUM_SOURCES];
	logic [DataW-1:0] men_q, sen_q;
	logic [PrioW-1:0] mthr_q, sthr_q;

	// result of the executed word, then the output register
	logic [DataW-1:0] res_data_q;
	logic             res_err_q;
	logic [DataW-1:0] read_data_q;
	logic             access_error_q, machine_irq_q, supervisor_irq_q;

	prio_vec_t        leaf_m, leaf_s;
	logic [SrcW-1:0]  best_m, best_s;
	logic [DataW-1:0] pend_vec;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action_t'(action);
			off_q    <= reg_offset;
			size_q   <= access_size;
			wdata_q  <= write_data;
			src_q    <= line_source;
			lvl_q    <= line_level;
		end
	end

	// candidates per context, then the tournament
	for (genvar gi = 0; gi < Leaves; gi++) begin : g_leaf
		if (gi >= 1 && gi <= NUM_SOURCES) begin : g_src
			logic free;
			assign free = pend_q[gi] && (owner_q[gi] == OwnerNone);
			assign leaf_m[gi] = (free && men_q[gi] && prio_q[gi] > mthr_q) ? prio_q[gi] : '0;
			assign leaf_s[gi] = (free && sen_q[gi] && prio_q[gi] > sthr_q) ? prio_q[gi] : '0;
			assign pend_vec[gi] = pend_q[gi];
		end else begin : g_none
			assign leaf_m[gi]   = '0;
			assign leaf_s[gi]   = '0;
			assign pend_vec[gi] = 1'b0;
		end
	end

	assign best_m = pick_best(leaf_m);
	assign best_s = pick_best(leaf_s);

	// decode of the latched access
	logic             size_ok, slot_hit, is_rd, is_wr, rd_hit, wr_hit;
	logic             hit_pend, hit_men, hit_sen, hit_mthr, hit_sthr, hit_mclm, hit_sclm;
	logic             do_wr, claim_m, claim_s, cpl_m, cpl_s, line_chg;
	logic [PrioW-1:0] prio_rd;
	logic [DataW-1:0] rdata;
	logic             err;

	assign size_ok  = (size_q == WordSize);
	assign slot_hit = (off_q[1:0] == 2'b00) && (off_q[OffW-1:2] != '0)
	                  && (off_q[OffW-1:2] <= (OffW-2)'(NUM_SOURCES));
	assign hit_pend = (off_q == OffPending);
	assign hit_men  = (off_q == OffMEnable);
	assign hit_sen  = (off_q == OffSEnable);
	assign hit_mthr = (off_q == OffMThresh);
	assign hit_sthr = (off_q == OffSThresh);
	assign hit_mclm = (off_q == OffMClaim);
	assign hit_sclm = (off_q == OffSClaim);
	assign is_rd    = (action_q == ActRead);
	assign is_wr    = (action_q == ActWrite);
	assign rd_hit   = slot_hit | hit_pend | hit_men | hit_sen | hit_mthr | hit_sthr
	                  | hit_mclm | hit_sclm;
	assign wr_hit   = slot_hit | hit_men | hit_sen | hit_mthr | hit_sthr | hit_mclm | hit_sclm;
	assign do_wr    = cmd.exec && is_wr && size_ok;
	assign claim_m  = cmd.exec && is_rd && size_ok && hit_mclm;
	assign claim_s  = cmd.exec && is_rd && size_ok && hit_sclm;
	assign cpl_m    = do_wr && hit_mclm;
	assign cpl_s    = do_wr && hit_sclm;
	assign line_chg = cmd.exec && (action_q == ActLine);

	always_comb begin
		prio_rd = '0;
		for (int i = 1; i <= NUM_SOURCES; i++) begin
			if (off_q[OffW-1:2] == (OffW-2)'(i))
				prio_rd = prio_q[i];
		end
	end

	always_comb begin
		rdata = '0;
		err   = 1'b0;
		case (action_q)
			ActRead: begin
				if (!size_ok || !rd_hit)
					err = 1'b1;
				else if (slot_hit)
					rdata = DataW'(prio_rd);
				else if (hit_pend)
					rdata = pend_vec;
				else if (hit_men)
					rdata = men_q;
				else if (hit_sen)
					rdata = sen_q;
				else if (hit_mthr)
					rdata = DataW'(mthr_q);
				else if (hit_sthr)
					rdata = DataW'(sthr_q);
				else if (hit_mclm)
					rdata = DataW'(best_m);
				else
					rdata = DataW'(best_s);
			end
			ActWrite: begin
				err = !size_ok || !wr_hit;
			end
			default: begin
				err = 1'b0;
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NUM_SOURCES; i++) begin
				prio_q[i]  <= '0;
				level_q[i] <= 1'b0;
				pend_q[i]  <= 1'b0;
				owner_q[i] <= OwnerNone;
			end
			men_q  <= '0;
			sen_q  <= '0;
			mthr_q <= '0;
			sthr_q <= '0;
		end else begin
			if (do_wr && hit_men)
				men_q <= wdata_q;
			if (do_wr && hit_sen)
				sen_q <= wdata_q;
			if (do_wr && hit_mthr)
				mthr_q <= wdata_q[PrioW-1:0];
			if (do_wr && hit_sthr)
				sthr_q <= wdata_q[PrioW-1:0];
			for (int i = 1; i <= NUM_SOURCES; i++) begin
				if (do_wr && slot_hit && off_q[OffW-1:2] == (OffW-2)'(i))
					prio_q[i] <= wdata_q[PrioW-1:0];
				if (line_chg && src_q == SrcW'(i)) begin
					level_q[i] <= lvl_q;
					if (lvl_q && owner_q[i] == OwnerNone)
						pend_q[i] <= 1'b1;
				end
				if ((claim_m && best_m == SrcW'(i)) || (claim_s && best_s == SrcW'(i))) begin
					pend_q[i]  <= 1'b0;
					owner_q[i] <= claim_m ? OwnerMachine : OwnerSuper;
				end
				if (wdata_q == DataW'(i)
				    && ((cpl_m && owner_q[i] == OwnerMachine)
				     || (cpl_s && owner_q[i] == OwnerSuper))) begin
					owner_q[i] <= OwnerNone;
					pend_q[i]  <= level_q[i];
				end
			end
		end
	end

	// result and output registers; irq flags sampled after the update
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_data_q <= rdata;
			res_err_q  <= err;
		end
		if (cmd.finish) begin
			read_data_q      <= res_data_q;
			access_error_q   <= res_err_q;
			machine_irq_q    <= (best_m != '0);
			supervisor_irq_q <= (best_s != '0);
		end
	end

	assign read_data      = read_data_q;
	assign access_error   = access_error_q;
	assign machine_irq    = machine_irq_q;
	assign supervisor_irq = supervisor_irq_q;

endmodule

`default_nettype wire

### sv/interrupt_claim_complete_controller_top.sv
// top level of the two-context interrupt claim/complete controller
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ----------------------------------------------
// in       sink       in_valid / in_stall  action, reg_offset, access_size, write_data,
//                                          line_source, line_level
// out      source     out_valid/out_stall  read_data, access_error, machine_irq,
//                                          supervisor_irq
//
// every word passes capture, execute against the source state, then the
// load of the output register with the irq flags taken from the updated state
// the claim winner comes from a 5-level priority tournament over all sources,
// evaluated combinationally from the state registers in the execute cycle
// one word in flight at a time; a new word is taken while the last result still
// waits in the output register, and only the load of the next result waits on out_stall
// arst_n clears the sequencer, all priorities, levels, pending bits, owners,
// enable masks and thresholds at once; no clearing pass is needed
`default_nettype none

module interrupt_claim_complete_controller_top
	import icc_pkg::*;
#(
	parameter int NUM_SOURCES = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       action,
	input  wire logic [OffW-1:0]  reg_offset,
	input  wire logic [SizeW-1:0] access_size,
	input  wire logic [DataW-1:0] write_data,
	input  wire logic [SrcW-1:0]  line_source,
	input  wire logic             line_level,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [DataW-1:0]      read_data,
	output logic                  access_error,
	output logic                  machine_irq,
	output logic                  supervisor_irq
);

	cmd_t cmd;

	// sequencer: idle -> execute -> finish
	icc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// source state, decode, arbitration and result registers
	icc_dp #(
		.NUM_SOURCES (NUM_SOURCES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.action         (action),
		.reg_offset     (reg_offset),
		.access_size    (access_size),
		.write_data     (write_data),
		.line_source    (line_source),
		.line_level     (line_level),
		.read_data      (read_data),
		.access_error   (access_error),
		.machine_irq    (machine_irq),
		.supervisor_irq (supervisor_irq)
	);

endmodule

`default_nettype wire

### tb/interrupt_claim_complete_controller_top_test.sv
// testbench of the interrupt claim/complete controller: directed and random words checked by a scoreboard
module interrupt_claim_complete_controller_top_test
	import icc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NumSources    = 31;
	localparam int RandomWords   = 1724;  // split over four phases
	localparam int HoldCycles    = 150;   // long receiver hold-off
	localparam int WatchdogLimit = 2000;  // cycles with no word moving on either side
	localparam int SettleCycles  = 8;     // idle wait before the final report
	localparam int MaxReports    = 10;

	// scoreboard: keeps its own copy of the source and context state, predicts the
	// result of every accepted input word and checks the results in order
	class claim_scoreboard;
		logic [PrioW-1:0] prio [Leaves];
		owner_t           owner [Leaves];
		logic [Leaves-1:0] level;
		logic [Leaves-1:0] pending;
		logic [DataW-1:0] m_enable;
		logic [DataW-1:0] s_enable;
		logic [PrioW-1:0] m_thresh;
		logic [PrioW-1:0] s_thresh;

		// expected results, oldest first: data, error, machine irq, supervisor irq
		logic [DataW-1:0] due_data [$];
		logic             due_error [$];
		logic             due_mirq [$];
		logic             due_sirq [$];

		int words;
		int claims;
		int completions;
		int errors;
		int checked;
		int mismatches;

		function new();
			for (int i = 0; i < Leaves; i++) begin
				prio[i]  = '0;
				owner[i] = OwnerNone;
			end
			level       = '0;
			pending     = '0;
			m_enable    = '0;
			s_enable    = '0;
			m_thresh    = '0;
			s_thresh    = '0;
			words       = 0;
			claims      = 0;
			completions = 0;
			errors      = 0;
			checked     = 0;
			mismatches  = 0;
		endfunction

		// highest priority source that could be handed to a context, lowest id on a tie
		function logic [SrcW-1:0] deliverable_source(logic [DataW-1:0] en, logic [PrioW-1:0] thr);
			logic [SrcW-1:0]  best;
			logic [PrioW-1:0] best_prio;
			best      = '0;
			best_prio = '0;
			for (int id = 1; id <= NumSources; id++) begin
				if (pending[id] && owner[id] == OwnerNone && en[id] && prio[id] > thr
						&& prio[id] > best_prio) begin
					best      = SrcW'(id);
					best_prio = prio[id];
				end
			end
			return best;
		endfunction

		function logic [SrcW-1:0] claim(owner_t who);
			logic [SrcW-1:0] id;
			if (who == OwnerMachine)
				id = deliverable_source(m_enable, m_thresh);
			else
				id = deliverable_source(s_enable, s_thresh);
			if (id != '0) begin
				pending[id] = 1'b0;
				owner[id]   = who;
				claims++;
			end
			return id;
		endfunction

		function void complete(owner_t who, logic [DataW-1:0] id);
			if (id == '0 || id > NumSources)
				return;
			if (owner[id[SrcW-1:0]] != who)
				return;
			owner[id[SrcW-1:0]]   = OwnerNone;
			pending[id[SrcW-1:0]] = level[id[SrcW-1:0]];
			completions++;
		endfunction

		// word-sized bus access; returns 0 for an unmapped offset or a write to pending
		function bit access_reg(logic is_write, logic [OffW-1:0] off, logic [DataW-1:0] wdata,
				output logic [DataW-1:0] rdata);
			rdata = '0;
			if (off[1:0] == 2'b00 && off != '0 && off <= OffW'(4 * NumSources)) begin
				if (is_write)
					prio[off[6:2]] = wdata[PrioW-1:0];
				else
					rdata = DataW'(prio[off[6:2]]);
				return 1'b1;
			end
			case (off)
				OffPending: begin
					if (is_write)
						return 1'b0;
					rdata = pending;
				end
				OffMEnable: begin
					if (is_write) m_enable = wdata;
					else rdata = m_enable;
				end
				OffSEnable: begin
					if (is_write) s_enable = wdata;
					else rdata = s_enable;
				end
				OffMThresh: begin
					if (is_write) m_thresh = wdata[PrioW-1:0];
					else rdata = DataW'(m_thresh);
				end
				OffSThresh: begin
					if (is_write) s_thresh = wdata[PrioW-1:0];
					else rdata = DataW'(s_thresh);
				end
				OffMClaim: begin
					if (is_write) complete(OwnerMachine, wdata);
					else rdata = DataW'(claim(OwnerMachine));
				end
				OffSClaim: begin
					if (is_write) complete(OwnerSuper, wdata);
					else rdata = DataW'(claim(OwnerSuper));
				end
				default: begin
					return 1'b0;
				end
			endcase
			return 1'b1;
		endfunction

		function void note_word(action_t act, logic [OffW-1:0] off, logic [SizeW-1:0] size,
				logic [DataW-1:0] wdata, logic [SrcW-1:0] src, logic lvl);
			logic [DataW-1:0] rdata;
			logic [DataW-1:0] data;
			logic             err;
			data = '0;
			err  = 1'b0;
			words++;
			case (act)
				ActRead, ActWrite: begin
					if (size != WordSize || !access_reg(act == ActWrite, off, wdata, rdata)) begin
						err = 1'b1;
						errors++;
					end else if (act == ActRead) begin
						data = rdata;
					end
				end
				ActLine: begin
					if (src != '0 && src <= NumSources) begin
						level[src] = lvl;
						if (lvl && owner[src] == OwnerNone)
							pending[src] = 1'b1;
					end
				end
				default: begin
				end
			endcase
			due_data.push_back(data);
			due_error.push_back(err);
			due_mirq.push_back(deliverable_source(m_enable, m_thresh) != '0);
			due_sirq.push_back(deliverable_source(s_enable, s_thresh) != '0);
		endfunction

		function void check_result(logic [DataW-1:0] data, logic err, logic mirq, logic sirq);
			logic [DataW-1:0] want_data;
			logic             want_err;
			logic             want_mirq;
			logic             want_sirq;
			if (due_data.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("unexpected result: data %h error %b mirq %b sirq %b",
						data, err, mirq, sirq);
				return;
			end
			want_data = due_data.pop_front();
			want_err  = due_error.pop_front();
			want_mirq = due_mirq.pop_front();
			want_sirq = due_sirq.pop_front();
			checked++;
			if (data !== want_data || err !== want_err || mirq !== want_mirq
					|| sirq !== want_sirq) begin
				mismatches++;
				if (mismatches <= MaxReports)
					$display("result %0d: expected data %h err %b mirq %b sirq %b, got %h %b %b %b",
						checked, want_data, want_err, want_mirq, want_sirq,
						data, err, mirq, sirq);
			end
		endfunction

		// a source currently held by a context, 0 if it holds none
		function logic [DataW-1:0] owned_source(owner_t who);
			int ids [$];
			for (int id = 1; id <= NumSources; id++)
				if (owner[id] == who)
					ids.push_back(id);
			if (ids.size() == 0)
				return '0;
			return DataW'(ids[$urandom_range(0, ids.size() - 1)]);
		endfunction

		function int awaiting();
			return due_data.size();
		endfunction
	endclass

	// clock, reset and the driven side of both channels, all known from time zero
	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             in_valid    = 1'b0;
	action_t          action      = ActTick;
	logic [OffW-1:0]  reg_offset  = '0;
	logic [SizeW-1:0] access_size = WordSize;
	logic [DataW-1:0] write_data  = '0;
	logic [SrcW-1:0]  line_source = '0;
	logic             line_level  = 1'b0;
	logic             out_stall   = 1'b0;

	wire logic             in_stall;
	wire logic             out_valid;
	wire logic [DataW-1:0] read_data;
	wire logic             access_error;
	wire logic             machine_irq;
	wire logic             supervisor_irq;

	claim_scoreboard sb = new();

	bit quiet        = 1'b0;  // no idling on either side while set
	bit hold_off_req = 1'b0;  // asks the receiver for one long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	interrupt_claim_complete_controller_top #(
		.NUM_SOURCES(NumSources)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.reg_offset    (reg_offset),
		.access_size   (access_size),
		.write_data    (write_data),
		.line_source   (line_source),
		.line_level    (line_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.read_data     (read_data),
		.access_error  (access_error),
		.machine_irq   (machine_irq),
		.supervisor_irq(supervisor_irq)
	);

	// idle length: mostly none or short, now and then a long one
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offsets lean on the claim registers so claim/complete sequences go deep;
	// a small share are near misses and raw noise to hit the unmapped decode
	function automatic logic [OffW-1:0] pick_offset();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return OffW'(4 * $urandom_range(1, NumSources));
		if (r < 38) return OffPending;
		if (r < 44) return OffMEnable;
		if (r < 50) return OffSEnable;
		if (r < 55) return OffMThresh;
		if (r < 60) return OffSThresh;
		if (r < 78) return OffMClaim;
		if (r < 94) return OffSClaim;
		if (r < 97) return OffW'(4 * $urandom_range(0, NumSources + 1) + $urandom_range(0, 3));
		return OffW'($urandom);
	endfunction

	// presents one word from a falling edge and holds it until taken; returns at
	// the falling edge after the accepting rising edge
	task automatic send_word(action_t act, logic [OffW-1:0] off, logic [SizeW-1:0] size,
			logic [DataW-1:0] wdata, logic [SrcW-1:0] src, logic lvl);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		action      <= act;
		reg_offset  <= off;
		access_size <= size;
		write_data  <= wdata;
		line_source <= src;
		line_level  <= lvl;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		@(negedge clk);
	endtask

	// unused payload fields carry noise on every directed word
	task automatic reg_read(logic [OffW-1:0] off);
		send_word(ActRead, off, WordSize, $urandom, SrcW'($urandom), 1'($urandom));
	endtask

	task automatic reg_write(logic [OffW-1:0] off, logic [DataW-1:0] wdata);
		send_word(ActWrite, off, WordSize, wdata, SrcW'($urandom), 1'($urandom));
	endtask

	task automatic set_line(logic [SrcW-1:0] src, logic lvl);
		send_word(ActLine, OffW'($urandom), SizeW'($urandom), $urandom, src, lvl);
	endtask

	// sender stops until every outstanding result is back
	task automatic wait_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.awaiting() != 0);
	endtask

	task automatic random_word();
		int               pick;
		action_t          act;
		logic [OffW-1:0]  off;
		logic [SizeW-1:0] size;
		logic [DataW-1:0] wdata;
		logic [SrcW-1:0]  src;
		logic             lvl;
		pick  = $urandom_range(0, 99);
		off   = pick_offset();
		size  = ($urandom_range(0, 19) == 0) ? SizeW'($urandom_range(0, 15)) : WordSize;
		wdata = $urandom;
		src   = SrcW'($urandom_range(0, 31));
		lvl   = ($urandom_range(0, 9) < 6);
		if (pick < 35) act = ActRead;
		else if (pick < 65) act = ActWrite;
		else if (pick < 90) act = ActLine;
		else act = ActTick;
		if (act == ActWrite) begin
			// low thresholds keep sources deliverable most of the time
			if ((off == OffMThresh || off == OffSThresh) && $urandom_range(0, 3) != 0)
				wdata[PrioW-1:0] = PrioW'($urandom_range(0, 2));
			// complete mostly a source that context really holds
			if (off == OffMClaim && $urandom_range(0, 9) < 7)
				wdata = sb.owned_source(OwnerMachine);
			if (off == OffSClaim && $urandom_range(0, 9) < 7)
				wdata = sb.owned_source(OwnerSuper);
			if ((off == OffMEnable || off == OffSEnable) && $urandom_range(0, 3) == 0)
				wdata = '1;
		end
		send_word(act, off, size, wdata, src, lvl);
	endtask

	// checks results first, then notes the input word taken at the same edge;
	// a result leaving now always belongs to an earlier word
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(read_data, access_error, machine_irq, supervisor_irq);
			if (in_valid && !in_stall)
				sb.note_word(action, reg_offset, access_size, write_data, line_source, line_level);
		end
	end

	// receiver: stall runs of random length, one long hold-off on request
	initial begin : receiver
		int run;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HoldCycles) @(negedge clk);
				hold_off_req = 1'b0;
				out_stall <= 1'b0;
				continue;
			end
			run = pick_gap();
			if (run > 0) begin
				out_stall <= 1'b1;
				repeat (run) @(negedge clk);
			end
			out_stall <= 1'b0;
			run = $urandom_range(1, 6);
			repeat (run - 1) @(negedge clk);
		end
	end

	// watchdog: ends the run when no word moves on either channel for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WatchdogLimit) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("timeout: no word moved for %0d cycles, %0d results outstanding",
			WatchdogLimit, sb.awaiting());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int n;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		reg_read(OffPending);                      // pending is all zero after reset
		reg_write(OffW'(4 * 1), 32'hFFFF_FFFF);    // priority masked to 3 bits
		reg_write(OffW'(4 * NumSources), 32'h3);   // last source
		reg_write(OffW'(4 * 5), 32'h0);            // priority zero never delivered
		reg_write(OffMEnable, 32'hFFFF_FFFF);      // enable bit 0 stored, no effect
		reg_write(OffSEnable, 32'h8000_0021);
		set_line(5'd1, 1'b1);
		set_line(SrcW'(NumSources), 1'b1);
		set_line(5'd5, 1'b1);
		set_line(5'd0, 1'b1);                      // source 0 ignored
		reg_read(OffPending);
		reg_read(OffSClaim);                       // last source, 5 has priority zero
		reg_read(OffMClaim);                       // source 1
		reg_read(OffMClaim);                       // nothing deliverable reads 0
		set_line(5'd1, 1'b0);                      // deassert while claimed
		reg_write(OffMClaim, DataW'(NumSources));  // machine does not own it: ignored
		reg_write(OffSClaim, DataW'(NumSources));  // line still high: pending again
		reg_write(OffMClaim, 32'd1);               // line low: stays clear
		reg_write(OffMClaim, 32'hFFFF_FFFF);       // id out of range: ignored
		reg_write(OffMThresh, 32'hFFFF_FFFF);      // threshold masked to 7
		reg_write(OffSThresh, 32'hFFFF_FFFA);
		reg_read(OffSClaim);                       // priority 3 above threshold 2
		reg_read(OffMThresh);
		reg_read(OffSEnable);
		send_word(ActRead, OffMClaim, 4'd8, $urandom, 5'd3, 1'b1);   // bad size, no claim
		send_word(ActWrite, OffMEnable, 4'd1, $urandom, 5'd3, 1'b0); // bad size
		reg_write(OffPending, 32'hFFFF_FFFF);      // pending is read only
		reg_read(22'h000000);                      // source 0 priority slot
		reg_read(22'h000006);                      // unaligned
		reg_read(OffW'(4 * (NumSources + 1)));     // past the last source
		send_word(ActTick, '1, '1, '1, '1, 1'b1);
		wait_results();

		// random part: phase 1 runs with no idling, phase 2 holds the receiver off
		// while words keep coming, every phase ends with all results back
		for (int phase = 0; phase < 4; phase++) begin
			quiet = (phase == 1);
			for (n = 0; n < RandomWords / 4; n++) begin
				if (phase == 2 && n == 40)
					hold_off_req = 1'b1;
				random_word();
			end
			wait_results();
		end
		quiet = 1'b0;

		repeat (SettleCycles) @(negedge clk);
		$display("covered %0d words with %0d results checked: %0d claims, %0d completions",
			sb.words, sb.checked, sb.claims, sb.completions);
		$display("%0d access errors expected, %0d mismatches", sb.errors, sb.mismatches);
		if (sb.mismatches == 0 && sb.awaiting() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
